FILE: design/erm_pkg.sv
// Shared types and constants for the Euler rotation matrix builder.
package erm_pkg;

  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned DEPTH   = 1 << ADDR_W;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned SAMP_W  = 16;
  localparam int unsigned PROD_W  = 32;

  localparam logic [ADDR_W-1:0] QUARTER_TURN = 12'h400;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_t;

  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic signed [SAMP_W-1:0]  samp_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [ANGLE_W-1:0]        angle_t;

endpackage

FILE: design/erm_if.sv
// Valid/ready channel interfaces for the input commands and the matrix results.
interface erm_in_if import erm_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   cmd;
  addr_t  table_index;
  samp_t  table_value;
  angle_t angle_a;
  angle_t angle_b;
  angle_t angle_c;

  modport source (output valid, cmd, table_index, table_value, angle_a, angle_b, angle_c,
                  input ready);
  modport sink   (input valid, cmd, table_index, table_value, angle_a, angle_b, angle_c,
                  output ready);
endinterface

interface erm_out_if import erm_pkg::*; ();
  logic  valid;
  logic  ready;
  samp_t m00;
  samp_t m01;
  samp_t m02;
  samp_t m10;
  samp_t m11;
  samp_t m12;
  samp_t m20;
  samp_t m21;
  samp_t m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

FILE: design/euler_rotation_matrix_builder.sv
// A compute transaction passes the table read registers, stages 2, 3 and 4 and the output register before out valid.
// Throughput: one transaction per cycle, table writes and computes alike, while the output is not stalled.
// A table write is stored in the tables and yields no result; every compute yields one.
// Three table copies (one per angle) each serve that angle's sine and cosine reads.
// Reset clears all pipeline valid bits; table contents are kept and undefined until written.
// Stages: table read, products, shift/negate, second product, sum/shift into output register.
module euler_rotation_matrix_builder import erm_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  erm_in_if.sink    in_ch,
  erm_out_if.source out_ch
);

  // Handshake chain: a stage takes new data when empty or when it drains.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_fire, is_compute, is_write;

  assign rdy5 = !v5_r || out_ch.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_ch.ready = rdy1;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_compute  = in_fire && (in_ch.cmd == CMD_COMPUTE);
  assign is_write    = in_fire && (in_ch.cmd == CMD_WRITE);

  // Stage 1: table reads
  addr_t ang_a, ang_b, ang_c;
  samp_t s1_sa_r, s1_ca_r, s1_sb_r, s1_cb_r, s1_sc_r, s1_cc_r;

  assign ang_a = in_ch.angle_a[ADDR_W-1:0];
  assign ang_b = in_ch.angle_b[ADDR_W-1:0];
  assign ang_c = in_ch.angle_c[ADDR_W-1:0];

  erm_sine_mem u_mem_a (
    .clk(clk), .wr_en(is_write), .wr_addr(in_ch.table_index), .wr_data(in_ch.table_value),
    .rd_en(is_compute), .rd_addr_a(ang_a), .rd_addr_b(ang_a + QUARTER_TURN),
    .rd_data_a_r(s1_sa_r), .rd_data_b_r(s1_ca_r)
  );

  erm_sine_mem u_mem_b (
    .clk(clk), .wr_en(is_write), .wr_addr(in_ch.table_index), .wr_data(in_ch.table_value),
    .rd_en(is_compute), .rd_addr_a(ang_b), .rd_addr_b(ang_b + QUARTER_TURN),
    .rd_data_a_r(s1_sb_r), .rd_data_b_r(s1_cb_r)
  );

  erm_sine_mem u_mem_c (
    .clk(clk), .wr_en(is_write), .wr_addr(in_ch.table_index), .wr_data(in_ch.table_value),
    .rd_en(is_compute), .rd_addr_a(ang_c), .rd_addr_b(ang_c + QUARTER_TURN),
    .rd_data_a_r(s1_sc_r), .rd_data_b_r(s1_cc_r)
  );

  // Stage 2: all first-level products
  logic  ld2;
  prod_t s2_sasb_r, s2_sacb_r, s2_casc_r, s2_cacc_r, s2_casb_r, s2_cacb_r;
  prod_t s2_cbcc_r, s2_sbcc_r, s2_cbsc_r, s2_sbsc_r;
  samp_t s2_sa_r, s2_sc_r, s2_cc_r;

  assign ld2 = rdy2 && v1_r;

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_sasb_r <= s1_sa_r * s1_sb_r;
      s2_sacb_r <= s1_sa_r * s1_cb_r;
      s2_casc_r <= s1_ca_r * s1_sc_r;
      s2_cacc_r <= s1_ca_r * s1_cc_r;
      s2_casb_r <= s1_ca_r * s1_sb_r;
      s2_cacb_r <= s1_ca_r * s1_cb_r;
      s2_cbcc_r <= s1_cb_r * s1_cc_r;
      s2_sbcc_r <= s1_sb_r * s1_cc_r;
      s2_cbsc_r <= s1_cb_r * s1_sc_r;
      s2_sbsc_r <= s1_sb_r * s1_sc_r;
      s2_sa_r   <= s1_sa_r;
      s2_sc_r   <= s1_sc_r;
      s2_cc_r   <= s1_cc_r;
    end
  end

  // Stage 3: negate and shift; finish the two-factor elements
  logic  ld3;
  prod_t neg_sasb, neg_sacb, neg_casc, neg_casb;
  prod_t t00_nxt, t02_nxt, t10_nxt, t12_nxt;
  prod_t e01_nxt, e11_nxt, e20_nxt, e22_nxt;
  prod_t s3_t00_r, s3_t02_r, s3_t10_r, s3_t12_r;
  prod_t s3_cbcc_r, s3_sbcc_r, s3_cbsc_r, s3_sbsc_r;
  samp_t s3_sc_r, s3_cc_r, s3_sa_r;
  samp_t s3_m01_r, s3_m11_r, s3_m20_r, s3_m22_r;

  assign ld3      = rdy3 && v2_r;
  assign neg_sasb = -s2_sasb_r;
  assign neg_sacb = -s2_sacb_r;
  assign neg_casc = -s2_casc_r;
  assign neg_casb = -s2_casb_r;
  assign t00_nxt  = neg_sasb >>> FRAC_BITS;
  assign t02_nxt  = s2_sacb_r >>> FRAC_BITS;
  assign t10_nxt  = s2_sasb_r >>> FRAC_BITS;
  assign t12_nxt  = neg_sacb >>> FRAC_BITS;
  assign e01_nxt  = neg_casc >>> FRAC_BITS;
  assign e11_nxt  = s2_cacc_r >>> FRAC_BITS;
  assign e20_nxt  = neg_casb >>> FRAC_BITS;
  assign e22_nxt  = s2_cacb_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_t00_r  <= t00_nxt;
      s3_t02_r  <= t02_nxt;
      s3_t10_r  <= t10_nxt;
      s3_t12_r  <= t12_nxt;
      s3_cbcc_r <= s2_cbcc_r;
      s3_sbcc_r <= s2_sbcc_r;
      s3_cbsc_r <= s2_cbsc_r;
      s3_sbsc_r <= s2_sbsc_r;
      s3_sc_r   <= s2_sc_r;
      s3_cc_r   <= s2_cc_r;
      s3_sa_r   <= s2_sa_r;
      s3_m01_r  <= e01_nxt[SAMP_W-1:0];
      s3_m11_r  <= e11_nxt[SAMP_W-1:0];
      s3_m20_r  <= e20_nxt[SAMP_W-1:0];
      s3_m22_r  <= e22_nxt[SAMP_W-1:0];
    end
  end

  // Stage 4: second product of the three-factor elements
  logic  ld4;
  prod_t s4_u00_r, s4_u02_r, s4_u10_r, s4_u12_r;
  prod_t s4_cbcc_r, s4_sbcc_r, s4_cbsc_r, s4_sbsc_r;
  samp_t s4_sa_r, s4_m01_r, s4_m11_r, s4_m20_r, s4_m22_r;

  assign ld4 = rdy4 && v3_r;

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_u00_r  <= s3_t00_r * s3_sc_r;
      s4_u02_r  <= s3_t02_r * s3_sc_r;
      s4_u10_r  <= s3_t10_r * s3_cc_r;
      s4_u12_r  <= s3_t12_r * s3_cc_r;
      s4_cbcc_r <= s3_cbcc_r;
      s4_sbcc_r <= s3_sbcc_r;
      s4_cbsc_r <= s3_cbsc_r;
      s4_sbsc_r <= s3_sbsc_r;
      s4_sa_r   <= s3_sa_r;
      s4_m01_r  <= s3_m01_r;
      s4_m11_r  <= s3_m11_r;
      s4_m20_r  <= s3_m20_r;
      s4_m22_r  <= s3_m22_r;
    end
  end

  // Stage 5: sum, shift and truncate into the output register
  logic  ld5;
  prod_t acc00, acc02, acc10, acc12;
  prod_t sh00, sh02, sh10, sh12;
  samp_t s5_m00_r, s5_m01_r, s5_m02_r, s5_m10_r, s5_m11_r;
  samp_t s5_m12_r, s5_m20_r, s5_m21_r, s5_m22_r;

  assign ld5   = rdy5 && v4_r;
  assign acc00 = s4_u00_r + s4_cbcc_r;
  assign acc02 = s4_u02_r + s4_sbcc_r;
  assign acc10 = s4_u10_r + s4_cbsc_r;
  assign acc12 = s4_u12_r + s4_sbsc_r;
  assign sh00  = acc00 >>> FRAC_BITS;
  assign sh02  = acc02 >>> FRAC_BITS;
  assign sh10  = acc10 >>> FRAC_BITS;
  assign sh12  = acc12 >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ld5) begin
      s5_m00_r <= sh00[SAMP_W-1:0];
      s5_m02_r <= sh02[SAMP_W-1:0];
      s5_m10_r <= sh10[SAMP_W-1:0];
      s5_m12_r <= sh12[SAMP_W-1:0];
      s5_m01_r <= s4_m01_r;
      s5_m11_r <= s4_m11_r;
      s5_m20_r <= s4_m20_r;
      s5_m21_r <= s4_sa_r;
      s5_m22_r <= s4_m22_r;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= is_compute;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  assign out_ch.valid = v5_r;
  assign out_ch.m00   = s5_m00_r;
  assign out_ch.m01   = s5_m01_r;
  assign out_ch.m02   = s5_m02_r;
  assign out_ch.m10   = s5_m10_r;
  assign out_ch.m11   = s5_m11_r;
  assign out_ch.m12   = s5_m12_r;
  assign out_ch.m20   = s5_m20_r;
  assign out_ch.m21   = s5_m21_r;
  assign out_ch.m22   = s5_m22_r;

endmodule

FILE: design/erm_sine_mem.sv
// Sine table copy: one write port, two registered read ports.
module erm_sine_mem import erm_pkg::*; (
  input  logic  clk,
  input  logic  wr_en,
  input  addr_t wr_addr,
  input  samp_t wr_data,
  input  logic  rd_en,
  input  addr_t rd_addr_a,
  input  addr_t rd_addr_b,
  output samp_t rd_data_a_r,
  output samp_t rd_data_b_r
);

  samp_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

endmodule

FILE: design/erm_checker.sv
// Port-level checks for the rotation matrix builder, bound to the top level.
module erm_checker import erm_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  out_valid,
  input logic  out_ready,
  input samp_t out_m00,
  input samp_t out_m11,
  input samp_t out_m21
);

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_m00) && $stable(out_m11) && $stable(out_m21))
    else $error("stalled result changed");

  // Reset empties the pipe.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // No result can appear sooner than the pipeline depth after reset.
  a_min_latency: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result appeared faster than the pipeline allows");

endmodule

bind euler_rotation_matrix_builder erm_checker u_erm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_m00   (out_ch.m00),
  .out_m11   (out_ch.m11),
  .out_m21   (out_ch.m21)
);
